### sv/text_line_number_and_escape_filter_macros.svh
// Assertion macros for the line-number and escape filter.
// Used by the queue and back-end modules; needs clk and rst_n in scope.
`ifndef TEXT_LINE_NUMBER_AND_ESCAPE_FILTER_MACROS_SVH
`define TEXT_LINE_NUMBER_AND_ESCAPE_FILTER_MACROS_SVH
`ifndef ASSERT_OFF
`define TLNEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLNEF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLNEF_ASSERT(lbl, prop, msg)
`define TLNEF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/tlnef_pkg.sv
// Shared types and constants of the line-number and escape filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlnef_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;
  localparam int QUEUE_DEPTH       = 4;
  localparam int ADDR_W            = 5;

  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NL        = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_DOLLAR    = 8'd36;
  localparam logic [7:0] CH_ZERO      = 8'd48;
  localparam logic [7:0] CH_I         = 8'd73;
  localparam logic [7:0] CH_CARET     = 8'd94;
  localparam logic [7:0] CH_DEL       = 8'd127;
  localparam logic [7:0] CTRL_MAX     = 8'd31;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  localparam logic [1:0] RUN_LIMIT = 2'd2;
  localparam logic [1:0] RUN_MAX   = 2'd3;

  typedef enum logic [2:0] {
    REG_NUMBER_NONBLANK  = 3'd0,
    REG_NUMBER_ALL       = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_TABS        = 3'd3,
    REG_SHOW_NONPRINTING = 3'd4,
    REG_SHOW_ENDS        = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_tabs;
    logic show_nonprinting;
    logic show_ends;
  } cfg_t;

  typedef struct packed {
    logic       number;
    logic       caret;
    logic       dollar;
    logic [7:0] ch;
  } cmd_t;

endpackage

`default_nettype wire

### sv/tlnef_if.sv
// Valid/ready channel interfaces for input bytes and output bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tlnef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_start;

  modport source (output valid, output in_byte, output file_start, input ready);
  modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

interface tlnef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

### sv/tlnef_cfg.sv
// APB-style register block holding the six filter option bits.
// Depends on tlnef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlnef_cfg import tlnef_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;
  logic     rd_bit;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_NUMBER_NONBLANK:  cfg_nxt.number_nonblank  = pwdata[0];
        REG_NUMBER_ALL:       cfg_nxt.number_all       = pwdata[0];
        REG_SQUEEZE_BLANK:    cfg_nxt.squeeze_blank    = pwdata[0];
        REG_SHOW_TABS:        cfg_nxt.show_tabs        = pwdata[0];
        REG_SHOW_NONPRINTING: cfg_nxt.show_nonprinting = pwdata[0];
        REG_SHOW_ENDS:        cfg_nxt.show_ends        = pwdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NUMBER_NONBLANK:  rd_bit = cfg_r.number_nonblank;
      REG_NUMBER_ALL:       rd_bit = cfg_r.number_all;
      REG_SQUEEZE_BLANK:    rd_bit = cfg_r.squeeze_blank;
      REG_SHOW_TABS:        rd_bit = cfg_r.show_tabs;
      REG_SHOW_NONPRINTING: rd_bit = cfg_r.show_nonprinting;
      REG_SHOW_ENDS:        rd_bit = cfg_r.show_ends;
      default:              rd_bit = 1'b0;
    endcase
  end

  assign prdata = {31'd0, rd_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/tlnef_front.sv
// Front end: accepts input bytes, tracks line count and newline run,
// and turns each kept byte into a command for the queue. Depends on tlnef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlnef_front import tlnef_pkg::*; #(
  parameter int ND = NUMBER_DIGITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  tlnef_in_if.sink           in_ch,
  input  wire cfg_t          cfg,
  input  wire logic          q_full,
  output logic               push,
  output cmd_t               cmd,
  output logic [4*ND-1:0]    cmd_bcd
);

  localparam int BCD_W = 4 * ND;

  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [1:0]       run_r, run_nxt;
  logic             als_r, als_nxt;

  logic [BCD_W-1:0] base_bcd;
  logic [1:0]       base_run;
  logic             base_als;
  logic [1:0]       run_n;
  logic [7:0]       c;
  logic             accept;
  logic             is_nl;
  logic             drop;
  logic             put_num;

  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic             carry;
    logic             all9;
    r     = v;
    all9  = 1'b1;
    carry = 1'b1;
    for (int i = 0; i < ND; i++) begin
      if (v[4*i +: 4] != 4'd9) all9 = 1'b0;
    end
    for (int i = 0; i < ND; i++) begin
      if (carry) begin
        if (v[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return all9 ? v : r;
  endfunction

  assign c           = in_ch.in_byte;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign is_nl       = (c == CH_NL);

  assign base_bcd = in_ch.file_start ? BCD_W'(1) : bcd_r;
  assign base_run = in_ch.file_start ? 2'd0 : run_r;
  assign base_als = in_ch.file_start ? 1'b1 : als_r;

  always_comb begin
    run_n = base_run;
    if (cfg.squeeze_blank) begin
      if (is_nl) begin
        run_n = (base_run == RUN_MAX) ? RUN_MAX : base_run + 2'd1;
      end else begin
        run_n = 2'd0;
      end
    end
  end

  assign drop = cfg.squeeze_blank && (run_n > RUN_LIMIT);

  always_comb begin
    if (cfg.number_nonblank) begin
      put_num = base_als && !is_nl;
    end else if (cfg.number_all) begin
      put_num = base_als;
    end else begin
      put_num = 1'b0;
    end
  end

  always_comb begin
    cmd.number = put_num;
    cmd.caret  = 1'b0;
    cmd.dollar = cfg.show_ends && is_nl;
    cmd.ch     = c;
    if (cfg.show_tabs && c == CH_TAB) begin
      cmd.caret = 1'b1;
      cmd.ch    = CH_I;
    end else if (cfg.show_nonprinting && !is_nl && c != CH_TAB) begin
      if (c <= CTRL_MAX) begin
        cmd.caret = 1'b1;
        cmd.ch    = c + CARET_OFFSET;
      end else if (c == CH_DEL) begin
        cmd.caret = 1'b1;
        cmd.ch    = c - CARET_OFFSET;
      end
    end
  end

  assign cmd_bcd = base_bcd;
  assign push    = accept && !drop;

  always_comb begin
    bcd_nxt = bcd_r;
    run_nxt = run_r;
    als_nxt = als_r;
    if (accept) begin
      run_nxt = run_n;
      bcd_nxt = base_bcd;
      als_nxt = base_als;
      if (!drop) begin
        if (put_num) begin
          bcd_nxt = bcd_inc(base_bcd);
          als_nxt = 1'b0;
        end
        if (is_nl) als_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcd_r <= BCD_W'(1);
      run_r <= 2'd0;
      als_r <= 1'b1;
    end else begin
      bcd_r <= bcd_nxt;
      run_r <= run_nxt;
      als_r <= als_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/tlnef_queue.sv
// Small register queue between front end and back end.
// Depends on tlnef_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "text_line_number_and_escape_filter_macros.svh"

module tlnef_queue import tlnef_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic              full,
  output logic              empty,
  output logic [W-1:0]      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == CW'(0));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `TLNEF_ASSERT_ALWAYS(a_count_bound, !rst_n || (count_r <= CW'(DEPTH)), "queue count above depth")
  `TLNEF_ASSERT(a_no_overrun, full |-> !push, "push into full queue")
  `TLNEF_ASSERT(a_count_track, (push && !pop) |=> (count_r == $past(count_r) + CW'(1)), "queue count lost a push")

endmodule

`default_nettype wire

### sv/tlnef_back.sv
// Back end: expands the queue head command into output bytes, one per cycle
// while the output is not stalled, into a registered output stage. Depends on tlnef_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "text_line_number_and_escape_filter_macros.svh"

module tlnef_back import tlnef_pkg::*; #(
  parameter int ND = NUMBER_DIGITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  input  wire logic [4*ND-1:0]  cmd_bcd,
  input  wire logic             q_empty,
  output logic                  pop,
  tlnef_out_if.source           out_ch
);

  localparam int PW = (ND > 1) ? $clog2(ND) : 1;

  typedef enum logic [5:0] {
    ST_START  = 6'b000001,
    ST_DIGIT  = 6'b000010,
    ST_TAB    = 6'b000100,
    ST_CARET  = 6'b001000,
    ST_DOLLAR = 6'b010000,
    ST_CHAR   = 6'b100000
  } step_t;

  step_t         state_r, state_nxt;
  step_t         cur;
  step_t         after_caret;
  step_t         after_tab;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          leading_r, leading_nxt;
  logic [PW-1:0] eff_pos;
  logic          eff_lead;
  logic [3:0]    digit;
  logic          lead_now;
  logic [7:0]    byte_val;
  logic          advance;
  logic          work;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  assign after_caret = cmd.dollar ? ST_DOLLAR : ST_CHAR;
  assign after_tab   = cmd.caret ? ST_CARET : after_caret;

  always_comb begin
    if (state_r == ST_START) begin
      if (cmd.number) begin
        cur = ST_DIGIT;
      end else begin
        cur = after_tab;
      end
    end else begin
      cur = state_r;
    end
  end

  assign eff_pos  = (state_r == ST_START) ? PW'(ND - 1) : pos_r;
  assign eff_lead = (state_r == ST_START) ? 1'b1 : leading_r;
  assign digit    = cmd_bcd[4*eff_pos +: 4];
  assign lead_now = eff_lead && (digit == 4'd0) && (eff_pos != PW'(0));

  always_comb begin
    case (cur)
      ST_DIGIT:  byte_val = lead_now ? CH_SPACE : CH_ZERO + {4'd0, digit};
      ST_TAB:    byte_val = CH_TAB;
      ST_CARET:  byte_val = CH_CARET;
      ST_DOLLAR: byte_val = CH_DOLLAR;
      ST_CHAR:   byte_val = cmd.ch;
      default:   byte_val = cmd.ch;
    endcase
  end

  assign advance = !out_valid_r || out_ch.ready;
  assign work    = advance && !q_empty;
  assign pop     = work && (cur == ST_CHAR);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    leading_nxt   = leading_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = !q_empty;
    end
    if (work) begin
      out_byte_nxt = byte_val;
      out_last_nxt = (cur == ST_CHAR);
      case (cur)
        ST_DIGIT: begin
          leading_nxt = lead_now;
          pos_nxt     = eff_pos - PW'(1);
          state_nxt   = (eff_pos == PW'(0)) ? ST_TAB : ST_DIGIT;
        end
        ST_TAB:    state_nxt = after_tab;
        ST_CARET:  state_nxt = after_caret;
        ST_DOLLAR: state_nxt = ST_CHAR;
        ST_CHAR:   state_nxt = ST_START;
        default:   state_nxt = ST_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_START;
      pos_r       <= '0;
      leading_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      leading_r   <= leading_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

  `TLNEF_ASSERT(a_mid_item_head, (state_r != ST_START) |-> !q_empty, "head lost during expansion")
  `TLNEF_ASSERT(a_pop_marks_last, pop |=> (out_valid_r && out_last_r), "pop without final byte")
  `TLNEF_ASSERT(a_hold_out, (out_valid_r && !out_ch.ready) |=> $stable(out_byte_r), "stalled byte moved")

endmodule

`default_nettype wire

### sv/text_line_number_and_escape_filter.sv
// Top level of the line-number and escape filter: registers, front end, command
// queue and back end. Depends on tlnef_pkg, tlnef_if and the tlnef_* modules.
//
// The filter takes one text byte per transfer and emits the bytes of a
// cat-style formatter: optional squeezing of newline runs, a right-aligned
// NUMBER_DIGITS wide line number plus tab, caret notation for tab, control
// bytes and 127, and a dollar before each newline; last marks the final
// output byte of each input byte. The front end accepts one byte per cycle
// while the four-entry command queue has room; a byte squeezed away gives no
// output. The back end emits one output byte per cycle while the output is
// ready; an input byte yields 1 to NUMBER_DIGITS + 3 output bytes (1 without
// numbering or escapes), which sets sustained throughput. The user must set
// options through the APB port only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module text_line_number_and_escape_filter import tlnef_pkg::*; #(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tlnef_in_if.sink               in_ch,
  tlnef_out_if.source            out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam int QW    = $bits(cmd_t) + BCD_W;

  cfg_t             cfg;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  cmd_t             f_cmd;
  logic [BCD_W-1:0] f_bcd;
  logic [QW-1:0]    q_head;
  cmd_t             b_cmd;
  logic [BCD_W-1:0] b_bcd;

  tlnef_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlnef_front #(.ND(NUMBER_DIGITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .q_full  (q_full),
    .push    (push),
    .cmd     (f_cmd),
    .cmd_bcd (f_bcd)
  );

  tlnef_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_cmd, f_bcd}),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  assign b_cmd = cmd_t'(q_head[QW-1:BCD_W]);
  assign b_bcd = q_head[BCD_W-1:0];

  tlnef_back #(.ND(NUMBER_DIGITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (b_cmd),
    .cmd_bcd (b_bcd),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
